### design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared widths, register map and defaults for the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MBPS_MAX_PATTERN_BYTES = 16;   // default and upper bound
    localparam int MBPS_BYTE_W            = 8;
    localparam int MBPS_LEN_W             = 5;    // holds 0..16
    localparam int MBPS_CNT_W             = 4;    // suppression count
    localparam int MBPS_ADDR_W            = 64;
    localparam int MBPS_PAT_W             = 128;  // 16 bytes of pattern or mask
    localparam int MBPS_REG_W             = 64;
    localparam int MBPS_PADDR_W           = 6;
    localparam int MBPS_IDX_W             = 3;

    // register indexes, at byte address 8*index
    localparam logic [MBPS_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [MBPS_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [MBPS_IDX_W-1:0] REG_MASK_LOW       = 3'd2;
    localparam logic [MBPS_IDX_W-1:0] REG_MASK_HIGH      = 3'd3;
    localparam logic [MBPS_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [MBPS_IDX_W-1:0] REG_REGION_BASE    = 3'd5;

endpackage

### design/mbps_window_match.sv
// ----------------------------------------------------------------------------
// mbps_window_match
// Masked compare of the newest len bytes of the window against the pattern.
// ----------------------------------------------------------------------------
module mbps_window_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MBPS_MAX_PATTERN_BYTES
) (
    input  logic [MAX_PATTERN_BYTES-1:0][MBPS_BYTE_W-1:0] window,
    input  logic [MBPS_PAT_W-1:0]                         pattern,
    input  logic [MBPS_PAT_W-1:0]                         mask,
    input  logic [MBPS_LEN_W-1:0]                         len,
    output logic                                          hit
);

    logic [MAX_PATTERN_BYTES-1:0] lane_ok;

    // Pattern byte i lines up with window entry len-1-i (entry 0 is newest).
    always_comb begin
        logic [MBPS_LEN_W-1:0]  sel;
        logic [MBPS_BYTE_W-1:0] d;
        logic [MBPS_BYTE_W-1:0] p;
        logic [MBPS_BYTE_W-1:0] m;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            sel = len - MBPS_LEN_W'(1) - MBPS_LEN_W'(i);
            d   = '0;
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                if (sel == MBPS_LEN_W'(j)) begin
                    d = window[j];
                end
            end
            p = pattern[MBPS_BYTE_W*i +: MBPS_BYTE_W];
            m = mask[MBPS_BYTE_W*i +: MBPS_BYTE_W];
            if (MBPS_LEN_W'(i) < len) begin
                lane_ok[i] = ((p & m) == (d & m));
            end else begin
                lane_ok[i] = 1'b1;
            end
        end
    end

    assign hit = &lane_ok;

endmodule

### design/masked_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Streaming masked byte pattern search with non-overlapping, left-first matches.
// ----------------------------------------------------------------------------
// Takes one region byte per cycle while s_ready is high and returns a result in
// the cycle after the byte is taken, when a match ends at that byte or the byte
// closes the region. The whole masked window compare, suppression and address
// add sit between the byte handshake and the result register, so throughput is
// one byte per clock while m_ready is high; the result register is the only
// buffer, so a stalled result holds off s_ready. Registers sit at byte address
// 8*index and should be written only while no request is in flight. Length zero
// never matches; lengths above MAX_PATTERN_BYTES are clipped.
module masked_byte_pattern_search_core
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MBPS_MAX_PATTERN_BYTES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [MBPS_PADDR_W-1:0] paddr,
    input  logic [MBPS_REG_W-1:0]   pwdata,
    output logic [MBPS_REG_W-1:0]   prdata,
    output logic                    pready,
    // byte stream
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MBPS_BYTE_W-1:0]  s_data_byte,
    input  logic                    s_is_last,
    // results
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_found,
    output logic [MBPS_ADDR_W-1:0]  m_match_address,
    output logic                    m_region_end
);

    localparam logic [MBPS_LEN_W-1:0] MAX_LEN = MBPS_LEN_W'(MAX_PATTERN_BYTES);

    // configuration registers
    logic [MBPS_REG_W-1:0]  pattern_low_reg;
    logic [MBPS_REG_W-1:0]  pattern_high_reg;
    logic [MBPS_REG_W-1:0]  mask_low_reg;
    logic [MBPS_REG_W-1:0]  mask_high_reg;
    logic [MBPS_LEN_W-1:0]  pattern_length_reg;
    logic [MBPS_ADDR_W-1:0] region_base_reg;

    logic [MBPS_IDX_W-1:0]  reg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[MBPS_PADDR_W-1 -: MBPS_IDX_W];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            mask_low_reg       <= '0;
            mask_high_reg      <= '0;
            pattern_length_reg <= '0;
            region_base_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                REG_MASK_LOW:       mask_low_reg       <= pwdata;
                REG_MASK_HIGH:      mask_high_reg      <= pwdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[MBPS_LEN_W-1:0];
                REG_REGION_BASE:    region_base_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_MASK_LOW:       prdata = mask_low_reg;
            REG_MASK_HIGH:      prdata = mask_high_reg;
            REG_PATTERN_LENGTH: prdata = MBPS_REG_W'(pattern_length_reg);
            REG_REGION_BASE:    prdata = region_base_reg;
            default:            prdata = '0;
        endcase
    end

    // scan state
    logic [MAX_PATTERN_BYTES-1:0][MBPS_BYTE_W-1:0] window_reg;
    logic [MAX_PATTERN_BYTES-1:0][MBPS_BYTE_W-1:0] window_next;
    logic [MBPS_ADDR_W-1:0] position_reg;
    logic [MBPS_ADDR_W-1:0] position_next;
    logic [MBPS_CNT_W-1:0]  suppress_reg;
    logic [MBPS_CNT_W-1:0]  suppress_next;

    logic [MAX_PATTERN_BYTES-1:0][MBPS_BYTE_W-1:0] window_shift;
    logic [MBPS_ADDR_W-1:0] position_inc;
    logic [MBPS_LEN_W-1:0]  len_eff;
    logic                   hit;
    logic                   found;
    logic                   emit;
    logic [MBPS_ADDR_W-1:0] addr;
    logic                   accept;

    assign accept = s_valid & s_ready;
    assign s_ready = ~m_valid | m_ready;

    always_comb begin
        window_shift[0] = s_data_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            window_shift[j] = window_reg[j-1];
        end
    end

    assign len_eff = (pattern_length_reg > MAX_LEN) ? MAX_LEN : pattern_length_reg;
    // saturating position
    assign position_inc = (&position_reg) ? position_reg : position_reg + MBPS_ADDR_W'(1);

    mbps_window_match #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_match (
        .window  (window_shift),
        .pattern ({pattern_high_reg, pattern_low_reg}),
        .mask    ({mask_high_reg, mask_low_reg}),
        .len     (len_eff),
        .hit     (hit)
    );

    always_comb begin
        found         = 1'b0;
        suppress_next = suppress_reg;
        if (suppress_reg != '0) begin
            suppress_next = suppress_reg - MBPS_CNT_W'(1);
        end else if (len_eff != '0 && position_inc >= MBPS_ADDR_W'(len_eff) && hit) begin
            found         = 1'b1;
            suppress_next = MBPS_CNT_W'(len_eff - MBPS_LEN_W'(1));
        end
        window_next   = window_shift;
        position_next = position_inc;
        if (s_is_last) begin
            window_next   = '0;
            position_next = '0;
            suppress_next = '0;
        end
    end

    assign addr = region_base_reg + position_inc - MBPS_ADDR_W'(len_eff);
    assign emit = found | s_is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            position_reg <= '0;
            suppress_reg <= '0;
        end else if (accept) begin
            window_reg   <= window_next;
            position_reg <= position_next;
            suppress_reg <= suppress_next;
        end
    end

    // result register
    logic                   m_valid_reg;
    logic                   m_found_reg;
    logic [MBPS_ADDR_W-1:0] m_match_address_reg;
    logic                   m_region_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_found_reg         <= found;
            m_match_address_reg <= found ? addr : '0;
            m_region_end_reg    <= s_is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_match_address_reg;
    assign m_region_end    = m_region_end_reg;

endmodule
